// File: rtl/core/assert_macros.svh
// assertion macros shared by the text line folder rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define TLF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TLF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tlf_pkg.sv
// shared types and constants of the text line folder
// no dependencies; used by every module of the block but tlf_ram
package tlf_pkg;

	localparam int CHAR_W     = 8;
	localparam int MAX_WIDTH  = 62;
	localparam int CNT_W      = 6;
	localparam int RING_DEPTH = 64;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int OCC_W      = $clog2(RING_DEPTH + 1);
	localparam int Q_DEPTH    = 4;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic [CHAR_W-1:0] SPACE_BYTE   = 8'd32;
	localparam logic [CHAR_W-1:0] TAB_BYTE     = 8'd9;
	localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;
	localparam logic [CNT_W-1:0]  WIDTH_RESET  = 6'd62;

	// one queued item of work: a piece, its newline, then an optional rest
	typedef struct packed {
		logic [PTR_W-1:0] start;
		logic [CNT_W-1:0] len1;
		logic [CNT_W-1:0] len2;
	} cmd_t;

	// write side of the character ring
	typedef struct packed {
		logic              en;
		logic [PTR_W-1:0]  addr;
		logic [CHAR_W-1:0] data;
	} ring_wr_t;

	// read side of the character ring
	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
	} ring_rd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_P1,
		BK_NL1,
		BK_P2,
		BK_NL2
	} bk_state_t;

	// width 0 acts as 1, anything above MAX_WIDTH (62) as MAX_WIDTH
	function automatic logic [CNT_W-1:0] clamp_width(input logic [CNT_W-1:0] w);
		logic [CNT_W-1:0] r;
		r = w;
		if (w == '0)
			r = CNT_W'(1);
		else if (w > CNT_W'(MAX_WIDTH))
			r = CNT_W'(MAX_WIDTH);
		return r;
	endfunction

endpackage

// File: rtl/core/tlf_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module tlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/tlf_cmd_queue.sv
// short fifo of piece commands between the front and back parts
// depends on tlf_pkg
module tlf_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tlf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output tlf_pkg::cmd_t pop_cmd,
	output logic          empty
);

	tlf_pkg::cmd_t                 slot_q [tlf_pkg::Q_DEPTH];
	logic [tlf_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [tlf_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [tlf_pkg::QCNT_W-1:0]    fill_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = fill_q == tlf_pkg::QCNT_W'(tlf_pkg::Q_DEPTH);
	assign empty   = fill_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// File: rtl/core/tlf_front.sv
// front part: takes characters, stores them in the ring, decides breaks
// depends on tlf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tlf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tlf_pkg::CHAR_W-1:0]     in_char,
	input  logic                           line_end,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tlf_pkg::CNT_W-1:0]      cfg_data,
	output tlf_pkg::ring_wr_t              ring_wr,
	input  logic                           ring_release,
	output logic                           q_push,
	output tlf_pkg::cmd_t                  q_cmd,
	input  logic                           q_full
);

	logic [tlf_pkg::CNT_W-1:0] fold_width_q;
	logic [tlf_pkg::CNT_W-1:0] width_q;
	logic [tlf_pkg::CNT_W-1:0] count_q;
	logic [tlf_pkg::CNT_W-1:0] blank_q;
	logic                      first_q;
	logic [tlf_pkg::PTR_W-1:0] head_q;
	logic [tlf_pkg::OCC_W-1:0] occ_q;

	logic                      acc;
	logic [tlf_pkg::CNT_W-1:0] w_eff;
	logic [tlf_pkg::CNT_W-1:0] new_cnt;
	logic [tlf_pkg::CNT_W-1:0] blank_new;
	logic [tlf_pkg::CNT_W-1:0] cut;
	logic [tlf_pkg::CNT_W-1:0] rest;
	logic                      is_blank;
	logic                      full;
	logic                      want_push;
	logic [tlf_pkg::CNT_W-1:0] count_d;
	logic [tlf_pkg::CNT_W-1:0] blank_d;
	logic                      first_d;
	logic [tlf_pkg::PTR_W-1:0] head_d;

	// flow control: room in the queue and in the ring
	assign in_stall  = q_full || (occ_q == tlf_pkg::OCC_W'(tlf_pkg::RING_DEPTH));
	assign acc       = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// width is taken at the first character of a line
	assign w_eff     = (count_q == '0 && first_q) ? tlf_pkg::clamp_width(fold_width_q) : width_q;
	assign new_cnt   = count_q + 1'b1;
	assign is_blank  = (in_char == tlf_pkg::SPACE_BYTE) || (in_char == tlf_pkg::TAB_BYTE);
	assign blank_new = is_blank ? new_cnt : blank_q;
	assign full      = new_cnt >= w_eff;
	assign cut       = (blank_new != '0) ? blank_new : new_cnt;
	assign rest      = new_cnt - cut;

	// store the character behind the segment
	assign ring_wr.en   = acc;
	assign ring_wr.addr = head_q + tlf_pkg::PTR_W'(count_q);
	assign ring_wr.data = in_char;

	// break decision
	always_comb begin
		want_push  = 1'b0;
		q_cmd      = '0;
		q_cmd.start = head_q;
		q_cmd.len1 = new_cnt;
		q_cmd.len2 = '0;
		count_d    = new_cnt;
		blank_d    = blank_new;
		first_d    = first_q;
		head_d     = head_q;
		if (full && first_q && line_end) begin
			// first segment ends the line right at the width: kept whole
			want_push = 1'b1;
			head_d    = head_q + tlf_pkg::PTR_W'(new_cnt);
			count_d   = '0;
			blank_d   = '0;
			first_d   = 1'b1;
		end else if (full) begin
			want_push  = 1'b1;
			q_cmd.len1 = cut;
			blank_d    = '0;
			if (line_end) begin
				q_cmd.len2 = rest;
				head_d     = head_q + tlf_pkg::PTR_W'(new_cnt);
				count_d    = '0;
				first_d    = 1'b1;
			end else begin
				head_d  = head_q + tlf_pkg::PTR_W'(cut);
				count_d = rest;
				first_d = 1'b0;
			end
		end else if (line_end) begin
			// remainder at end of line
			want_push = 1'b1;
			head_d    = head_q + tlf_pkg::PTR_W'(new_cnt);
			count_d   = '0;
			blank_d   = '0;
			first_d   = 1'b1;
		end
	end

	assign q_push = acc && want_push;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fold_width_q <= tlf_pkg::WIDTH_RESET;
		else if (cfg_valid && cfg_ready)
			fold_width_q <= cfg_data;
	end

	// segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= tlf_pkg::WIDTH_RESET;
			count_q <= '0;
			blank_q <= '0;
			first_q <= 1'b1;
			head_q  <= '0;
		end else if (acc) begin
			width_q <= w_eff;
			count_q <= count_d;
			blank_q <= blank_d;
			first_q <= first_d;
			head_q  <= head_d;
		end
	end

	// ring occupancy: characters written and not yet read by the back part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else if (acc && !ring_release)
			occ_q <= occ_q + 1'b1;
		else if (ring_release && !acc)
			occ_q <= occ_q - 1'b1;
	end

	`TLF_ASSERT(a_line_end_clears, (acc && line_end) |=> (count_q == '0 && first_q), "segment not cleared at end of line")
	`TLF_ASSERT(a_segment_in_ring, (tlf_pkg::OCC_W'(count_q) <= occ_q), "segment larger than ring occupancy")

endmodule

// File: rtl/core/tlf_back.sv
// back part: plays queued pieces out of the ring with their newlines
// depends on tlf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tlf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  tlf_pkg::cmd_t              q_cmd,
	output logic                       q_pop,
	output tlf_pkg::ring_rd_t          ring_rd,
	input  logic [tlf_pkg::CHAR_W-1:0] ring_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tlf_pkg::CHAR_W-1:0] out_char,
	output logic                       run_last
);

	tlf_pkg::bk_state_t        state_q;
	tlf_pkg::bk_state_t        state_d;
	logic [tlf_pkg::PTR_W-1:0] addr_q;
	logic [tlf_pkg::PTR_W-1:0] addr_d;
	logic [tlf_pkg::CNT_W-1:0] rem_q;
	logic [tlf_pkg::CNT_W-1:0] rem_d;
	logic [tlf_pkg::CNT_W-1:0] len2_q;
	logic [tlf_pkg::CNT_W-1:0] len2_d;

	logic                      valid_s1;
	logic                      nl_s1;
	logic                      last_s1;
	logic                      valid_s2;
	logic [tlf_pkg::CHAR_W-1:0] char_s2;
	logic                      last_s2;

	logic                      s2_ready;
	logic                      s1_adv;
	logic                      issue_ok;
	logic                      issue;
	logic                      issue_nl;
	logic                      issue_last;

	// pipeline handshake
	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_adv   = valid_s1 && s2_ready;
	assign issue_ok = !valid_s1 || s1_adv;

	// sequencer: next state and issue slot
	always_comb begin
		state_d    = state_q;
		addr_d     = addr_q;
		rem_d      = rem_q;
		len2_d     = len2_q;
		q_pop      = 1'b0;
		issue      = 1'b0;
		issue_nl   = 1'b0;
		issue_last = 1'b0;
		unique case (state_q) inside
			tlf_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					addr_d  = q_cmd.start;
					rem_d   = q_cmd.len1;
					len2_d  = q_cmd.len2;
					state_d = (q_cmd.len1 != '0) ? tlf_pkg::BK_P1 : tlf_pkg::BK_NL1;
				end
			end
			tlf_pkg::BK_P1, tlf_pkg::BK_P2: begin
				issue = issue_ok;
				if (issue_ok) begin
					addr_d = addr_q + 1'b1;
					rem_d  = rem_q - 1'b1;
					if (rem_q == tlf_pkg::CNT_W'(1))
						state_d = (state_q == tlf_pkg::BK_P1) ? tlf_pkg::BK_NL1 : tlf_pkg::BK_NL2;
				end
			end
			tlf_pkg::BK_NL1: begin
				issue      = issue_ok;
				issue_nl   = 1'b1;
				issue_last = len2_q == '0;
				if (issue_ok) begin
					if (len2_q == '0) begin
						state_d = tlf_pkg::BK_IDLE;
					end else begin
						rem_d   = len2_q;
						state_d = tlf_pkg::BK_P2;
					end
				end
			end
			tlf_pkg::BK_NL2: begin
				issue      = issue_ok;
				issue_nl   = 1'b1;
				issue_last = 1'b1;
				if (issue_ok)
					state_d = tlf_pkg::BK_IDLE;
			end
			default: begin
				state_d = tlf_pkg::BK_IDLE;
			end
		endcase
	end

	// ring read for character slots only
	assign ring_rd.en   = issue && !issue_nl;
	assign ring_rd.addr = addr_q;

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tlf_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		rem_q  <= rem_d;
		len2_q <= len2_d;
	end

	// stage 1: slot waits for ring read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (issue_ok)
			valid_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		if (issue_ok) begin
			nl_s1   <= issue_nl;
			last_s1 <= issue_last;
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_ready)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			char_s2 <= nl_s1 ? tlf_pkg::NEWLINE_BYTE : ring_data;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_char  = char_s2;
	assign run_last  = last_s2;

	`TLF_ASSERT(a_last_is_newline, (valid_s2 && last_s2) |-> (char_s2 == tlf_pkg::NEWLINE_BYTE), "item closed by a non-newline byte")
	`TLF_ASSERT(a_pop_starts_work, (state_q == tlf_pkg::BK_IDLE && !q_empty) |=> (state_q != tlf_pkg::BK_IDLE), "queued command not started")
	`TLF_ASSERT_ALWAYS(a_read_in_char_state, ring_rd.en |-> (state_q == tlf_pkg::BK_P1 || state_q == tlf_pkg::BK_P2), "ring read outside a piece")

endmodule

// File: rtl/core/text_line_folder_unit.sv
// top level of the text line folder: front, command queue, ring, back
// depends on tlf_pkg, tlf_ram, tlf_cmd_queue, tlf_front, tlf_back
//
//   channel   signals                           flow control
//   input     in_char, line_end                 in_valid / in_stall
//   output    out_char, run_last                out_valid / out_stall
//   config    cfg_data (fold_width)             cfg_valid / cfg_ready
//
// the front takes one character per cycle while the command queue and the
// 64-entry character ring have room.
// the back sends one byte per cycle out of the ring while out_stall is low,
// and pauses in its idle state to load each piece command.
// queued pieces leave the ring through back stage 1 and stage 2 registers.
// no clearing pass after reset; cfg_ready is always high.
module text_line_folder_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tlf_pkg::CHAR_W-1:0]     in_char,
	input  logic                           line_end,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tlf_pkg::CHAR_W-1:0]     out_char,
	output logic                           run_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tlf_pkg::CNT_W-1:0]      cfg_data
);

	tlf_pkg::ring_wr_t          ring_wr;
	tlf_pkg::ring_rd_t          ring_rd;
	logic [tlf_pkg::CHAR_W-1:0] ring_data;
	logic                       q_push;
	logic                       q_full;
	logic                       q_pop;
	logic                       q_empty;
	tlf_pkg::cmd_t              push_cmd;
	tlf_pkg::cmd_t              pop_cmd;

	// front part
	tlf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_char      (in_char),
		.line_end     (line_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.ring_wr      (ring_wr),
		.ring_release (ring_rd.en),
		.q_push       (q_push),
		.q_cmd        (push_cmd),
		.q_full       (q_full)
	);

	// command queue
	tlf_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// character ring
	tlf_ram #(
		.WIDTH (tlf_pkg::CHAR_W),
		.DEPTH (tlf_pkg::RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_wr.en),
		.wr_addr (ring_wr.addr),
		.wr_data (ring_wr.data),
		.rd_en   (ring_rd.en),
		.rd_addr (ring_rd.addr),
		.rd_data (ring_data)
	);

	// back part
	tlf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.ring_rd   (ring_rd),
		.ring_data (ring_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.run_last  (run_last)
	);

endmodule
